[design/ecpad_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpad_pkg
// Shared types and codes for the affine point unit.
// ----------------------------------------------------------------------------
package ecpad_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DOUBLE = 2'd1,
        OP_NEGATE = 2'd2,
        OP_NEG_ALT = 2'd3
    } op_t;

    localparam logic [0:0] CFG_MODULUS = 1'b0;
    localparam logic [0:0] CFG_COEF_A  = 1'b1;

    localparam int REG_BITS = 16;
    localparam logic [REG_BITS-1:0] MODULUS_RESET = 16'd65521;

    typedef enum logic [1:0] {
        ALU_MUL = 2'd0,
        ALU_RED = 2'd1,
        ALU_DIV = 2'd2
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctl_t;

endpackage

[design/ecpad_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpad_alu
// Bit-serial shared unit: modular multiply, reduction and integer divide.
// ----------------------------------------------------------------------------
module ecpad_alu
    import ecpad_pkg::*;
#(
    parameter int W = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  alu_ctl_t       ctl,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    input  logic [W-1:0]   m,
    output logic           done,
    output logic [W-1:0]   q,
    output logic [W-1:0]   r
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  acc_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  m_reg;
    alu_op_t       op_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W:0]    dbl;
    logic [W:0]    dred;
    logic [W-1:0]  step1;
    logic [W:0]    sum;
    logic [W-1:0]  step2;
    logic          bit_in;

    always_comb
    begin
        bit_in = (op_reg == ALU_MUL) ? 1'b0 : b_reg[W-1];
        dbl    = {acc_reg, bit_in};
        dred   = dbl - {1'b0, m_reg};
        step1  = (dbl >= {1'b0, m_reg}) ? dred[W-1:0] : dbl[W-1:0];
        sum    = {1'b0, step1} + {1'b0, a_reg};
        if (op_reg == ALU_MUL && b_reg[W-1])
        begin
            step2 = (sum >= {1'b0, m_reg}) ? W'(sum - {1'b0, m_reg}) : sum[W-1:0];
        end
        else
        begin
            step2 = step1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= ALU_MUL;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
                op_reg   <= ctl.op;
                acc_reg  <= '0;
                quo_reg  <= '0;
                a_reg    <= a;
                b_reg    <= b;
                m_reg    <= (ctl.op == ALU_DIV) ? b : m;
                if (ctl.op != ALU_MUL)
                begin
                    b_reg <= a;
                end
            end
            else if (busy_reg)
            begin
                acc_reg <= step2;
                quo_reg <= {quo_reg[W-2:0], dbl >= {1'b0, m_reg}};
                b_reg   <= {b_reg[W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = quo_reg;
    assign r    = acc_reg;

endmodule

[design/ec_point_add_double_negate_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ec_point_add_double_negate_top
// Affine add, double and negate of elliptic-curve points over a prime field.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the result strobe, which lasts one cycle and cannot be held off. Multiply,
// reduce and divide steps all run on one shared bit-serial unit. Unless the
// modulus is below 2, every item first spends five reduce steps on its
// coordinates and the coefficient, after which a negate finishes without using
// the unit again. Add and double then run the Euclid inverse at two unit steps,
// a divide and a multiply, per iteration and finish with three multiplies;
// double spends two more multiplies on its numerator. The Euclid loop sets the
// cost of an add or double.
module ec_point_add_double_negate_top
    import ecpad_pkg::*;
#(
    parameter int FIELD_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [REG_BITS-1:0]   cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            operation,
    input  logic [FIELD_BITS-1:0] x_first,
    input  logic [FIELD_BITS-1:0] y_first,
    input  logic [FIELD_BITS-1:0] x_second,
    input  logic [FIELD_BITS-1:0] y_second,
    output logic                  result_valid,
    output logic [REG_BITS-1:0]   x_result,
    output logic [REG_BITS-1:0]   y_result,
    output logic                  status
);

    localparam int W = FIELD_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_RX1, S_RY1, S_RX2, S_RY2, S_RA, S_PREP,
        S_T3, S_T3X, S_NUM, S_EU_DIV, S_EU_MUL, S_EU_NEXT,
        S_LAM, S_LL, S_X3, S_Y3, S_DONE
    } state_t;

    state_t         state_reg;
    logic [W-1:0]   p_reg, ca_reg;
    logic [1:0]     op_reg;
    logic [W-1:0]   x1_reg, y1_reg, x2_reg, y2_reg, a_reg;
    logic [W-1:0]   num_reg, r0_reg, r1_reg, t0_reg, t1_reg, qt_reg, rem_reg;
    logic [W-1:0]   lam_reg, x3_reg;
    logic           issued_reg;
    logic           st_reg;

    alu_ctl_t       ctl;
    logic [W-1:0]   alu_a, alu_b;
    logic           alu_done;
    logic [W-1:0]   alu_q, alu_r;

    ecpad_alu #(.W(W)) u_alu (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .a(alu_a), .b(alu_b), .m(p_reg),
        .done(alu_done), .q(alu_q), .r(alu_r)
    );

    function automatic logic [W-1:0] fadd(input logic [W-1:0] x, input logic [W-1:0] y,
                                          input logic [W-1:0] m);
        logic [W-1:0] room;
        room = m - y;
        return (x >= room) ? x - room : x + y;
    endfunction

    function automatic logic [W-1:0] fsub(input logic [W-1:0] x, input logic [W-1:0] y,
                                          input logic [W-1:0] m);
        return (x >= y) ? x - y : x + (m - y);
    endfunction

    always_comb
    begin
        ctl.start = 1'b0;
        ctl.op    = ALU_RED;
        alu_a     = '0;
        alu_b     = '0;
        if (!issued_reg)
        begin
            ctl.start = 1'b1;
            unique case (state_reg)
                S_RX1:    begin alu_a = x1_reg; end
                S_RY1:    begin alu_a = y1_reg; end
                S_RX2:    begin alu_a = x2_reg; end
                S_RY2:    begin alu_a = y2_reg; end
                S_RA:     begin alu_a = ca_reg; end
                S_T3:     begin ctl.op = ALU_MUL; alu_a = x1_reg; alu_b = x1_reg; end
                S_T3X:    begin ctl.op = ALU_MUL; alu_a = num_reg; alu_b = (W)'(3); end
                S_EU_DIV: begin ctl.op = ALU_DIV; alu_a = r0_reg; alu_b = r1_reg; end
                S_EU_MUL: begin ctl.op = ALU_MUL; alu_a = qt_reg; alu_b = t1_reg; end
                S_LAM:    begin ctl.op = ALU_MUL; alu_a = num_reg; alu_b = t0_reg; end
                S_LL:     begin ctl.op = ALU_MUL; alu_a = lam_reg; alu_b = lam_reg; end
                S_Y3:     begin ctl.op = ALU_MUL; alu_a = lam_reg;
                                alu_b = fsub(x1_reg, x3_reg, p_reg); end
                default:  begin ctl.start = 1'b0; end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            p_reg        <= W'(MODULUS_RESET);
            ca_reg       <= '0;
            issued_reg   <= 1'b0;
            result_valid <= 1'b0;
            x_result     <= '0;
            y_result     <= '0;
            status       <= 1'b0;
        end
        else
        begin
            result_valid <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == CFG_MODULUS) p_reg <= W'(cfg_data);
                else                          ca_reg <= W'(cfg_data);
            end
            if (ctl.start) issued_reg <= 1'b1;
            if (alu_done)  issued_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg <= operation;
                        x1_reg <= x_first;  y1_reg <= y_first;
                        x2_reg <= x_second; y2_reg <= y_second;
                        st_reg <= 1'b0;
                        x3_reg <= '0;
                        t0_reg <= '0;
                        issued_reg <= 1'b0;
                        state_reg <= (p_reg < W'(2)) ? S_DONE : S_RX1;
                        if (p_reg < W'(2)) st_reg <= 1'b1;
                    end
                end
                S_RX1: if (alu_done) begin x1_reg <= alu_r; state_reg <= S_RY1; end
                S_RY1: if (alu_done) begin y1_reg <= alu_r; state_reg <= S_RX2; end
                S_RX2: if (alu_done) begin x2_reg <= alu_r; state_reg <= S_RY2; end
                S_RY2: if (alu_done) begin y2_reg <= alu_r; state_reg <= S_RA; end
                S_RA:  if (alu_done) begin a_reg  <= alu_r; state_reg <= S_PREP; end
                S_PREP:
                begin
                    if (op_reg[1])
                    begin
                        x3_reg    <= x1_reg;
                        lam_reg   <= fsub('0, y1_reg, p_reg);
                        state_reg <= S_DONE;
                    end
                    else if (op_reg == OP_ADD)
                    begin
                        num_reg <= fsub(y2_reg, y1_reg, p_reg);
                        r1_reg  <= fsub(x2_reg, x1_reg, p_reg);
                        r0_reg  <= p_reg;
                        t0_reg  <= '0;
                        t1_reg  <= W'(1);
                        state_reg <= S_EU_NEXT;
                    end
                    else
                    begin
                        x2_reg  <= x1_reg;
                        r1_reg  <= fadd(y1_reg, y1_reg, p_reg);
                        r0_reg  <= p_reg;
                        t0_reg  <= '0;
                        t1_reg  <= W'(1);
                        state_reg <= S_T3;
                    end
                end
                S_T3:  if (alu_done) begin num_reg <= alu_r; state_reg <= S_T3X; end
                S_T3X: if (alu_done) begin num_reg <= alu_r; state_reg <= S_NUM; end
                S_NUM:
                begin
                    num_reg   <= fadd(num_reg, a_reg, p_reg);
                    state_reg <= S_EU_NEXT;
                end
                S_EU_NEXT:
                begin
                    if (r1_reg == '0)
                    begin
                        if (r0_reg != W'(1))
                        begin
                            st_reg    <= 1'b1;
                            x3_reg    <= '0;
                            lam_reg   <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_LAM;
                        end
                    end
                    else
                    begin
                        state_reg <= S_EU_DIV;
                    end
                end
                S_EU_DIV:
                begin
                    if (alu_done)
                    begin
                        qt_reg    <= (alu_q >= p_reg) ? alu_q - p_reg : alu_q;
                        rem_reg   <= alu_r;
                        state_reg <= S_EU_MUL;
                    end
                end
                S_EU_MUL:
                begin
                    if (alu_done)
                    begin
                        t1_reg    <= fsub(t0_reg, alu_r, p_reg);
                        t0_reg    <= t1_reg;
                        r0_reg    <= r1_reg;
                        r1_reg    <= rem_reg;
                        state_reg <= S_EU_NEXT;
                    end
                end
                S_LAM: if (alu_done) begin lam_reg <= alu_r; state_reg <= S_LL; end
                S_LL:
                begin
                    if (alu_done)
                    begin
                        x3_reg    <= fsub(fsub(alu_r, x1_reg, p_reg), x2_reg, p_reg);
                        state_reg <= S_Y3;
                    end
                end
                S_Y3:
                begin
                    if (alu_done)
                    begin
                        lam_reg   <= fsub(alu_r, y1_reg, p_reg);
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    result_valid <= 1'b1;
                    x_result     <= REG_BITS'(x3_reg);
                    y_result     <= st_reg ? '0 : REG_BITS'(lam_reg);
                    status       <= st_reg;
                    state_reg    <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[dv/ec_point_add_double_negate_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ec_point_add_double_negate_top_test
// Self-checking bench for the affine add, double and negate point unit.
// ----------------------------------------------------------------------------
// A directed table covers extremes and the special cases. Random points then
// run under several moduli and curve coefficients, with random start gaps.
// Every result is checked against the table's known values or a behavioral point predictor.
module ec_point_add_double_negate_top_test;
    import ecpad_pkg::*;

    typedef struct {
        op_t         op;
        logic [15:0] x1;
        logic [15:0] y1;
        logic [15:0] x2;
        logic [15:0] y2;
        bit          known;
        logic [15:0] ex;
        logic [15:0] ey;
        logic        est;
    } point_row_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic        st;
    } point_res_t;

    typedef struct {
        logic [15:0] modulus;
        logic [15:0] coef;
        int          count;
    } field_phase_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [0:0]          cfg_index;
    logic [REG_BITS-1:0] cfg_data;
    logic                start;
    logic                busy;
    logic [1:0]          operation;
    logic [15:0]         x_first;
    logic [15:0]         y_first;
    logic [15:0]         x_second;
    logic [15:0]         y_second;
    logic                result_valid;
    logic [15:0]         x_result;
    logic [15:0]         y_result;
    logic                status;

    longint unsigned field_mod;
    longint unsigned field_coef;
    point_res_t      pending_points[$];
    int              mismatches;
    longint          cycles;

    ec_point_add_double_negate_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .x_first      (x_first),
        .y_first      (y_first),
        .x_second     (x_second),
        .y_second     (y_second),
        .result_valid (result_valid),
        .x_result     (x_result),
        .y_result     (y_result),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic point_res_t point_op(logic [1:0] op, logic [15:0] x1_in,
                                            logic [15:0] y1_in, logic [15:0] x2_in,
                                            logic [15:0] y2_in);
        point_res_t      res;
        longint unsigned p;
        longint unsigned x1;
        longint unsigned y1;
        longint unsigned x2;
        longint unsigned y2;
        longint unsigned num;
        longint unsigned den;
        longint unsigned lam;
        longint          r0;
        longint          r1;
        longint          t0;
        longint          t1;
        longint          q;
        longint          tmp;
        res = '0;
        p = field_mod;
        if (p < 2)
        begin
            res.st = 1'b1;
            return res;
        end
        x1 = x1_in % p;
        y1 = y1_in % p;
        x2 = x2_in % p;
        y2 = y2_in % p;
        if (op == OP_NEGATE || op == OP_NEG_ALT)
        begin
            res.x = x1[15:0];
            res.y = 16'((p - y1) % p);
            return res;
        end
        if (op == OP_ADD)
        begin
            num = (y2 + p - y1) % p;
            den = (x2 + p - x1) % p;
        end
        else
        begin
            x2 = x1;
            num = ((3 * x1 % p) * x1 % p + field_coef % p) % p;
            den = (2 * y1) % p;
        end
        r0 = p;
        r1 = den;
        t0 = 0;
        t1 = 1;
        while (r1 != 0)
        begin
            q = r0 / r1;
            tmp = r0 - q * r1;
            r0 = r1;
            r1 = tmp;
            tmp = t0 - q * t1;
            t0 = t1;
            t1 = tmp;
        end
        if (r0 != 1)
        begin
            res.st = 1'b1;
            return res;
        end
        t0 = ((t0 % longint'(p)) + longint'(p)) % longint'(p);
        lam = num * longint'(t0) % p;
        res.x = 16'((lam * lam % p + 2 * p - x1 - x2) % p);
        res.y = 16'((lam * ((x1 + p - res.x) % p) % p + p - y1) % p);
        return res;
    endfunction

    task automatic write_reg(logic [0:0] idx, logic [15:0] value);
        while (pending_points.size() != 0 || busy)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_MODULUS)
            field_mod = value;
        else
            field_coef = value;
    endtask

    task automatic issue_point(point_row_t row);
        int         gap;
        point_res_t res;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        operation <= row.op;
        x_first   <= row.x1;
        y_first   <= row.y1;
        x_second  <= row.x2;
        y_second  <= row.y2;
        do
            @(posedge clk);
        while (busy);
        res = point_op(row.op, row.x1, row.y1, row.x2, row.y2);
        if (row.known)
        begin
            res.x  = row.ex;
            res.y  = row.ey;
            res.st = row.est;
        end
        pending_points.push_back(res);
    endtask

    function automatic logic [15:0] draw_coord();
        logic [15:0] v;
        v = 16'($urandom);
        if ($urandom_range(0, 3) != 0 && field_mod != 0)
            v = 16'(v % field_mod);
        return v;
    endfunction

    always @(posedge clk)
    begin
        point_res_t want;
        if (rst_n && result_valid)
        begin
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer x=%0d y=%0d st=%0d",
                             x_result, y_result, status);
            end
            else
            begin
                want = pending_points.pop_front();
                if (x_result !== want.x || y_result !== want.y || status !== want.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected x=%0d y=%0d st=%0d, got x=%0d y=%0d st=%0d",
                                 want.x, want.y, want.st, x_result, y_result, status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 40_000_000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        point_row_t   directed[$];
        point_row_t   row;
        field_phase_t phases[$];
        int           pick;
        mismatches = 0;
        cycles     = 0;
        field_mod  = MODULUS_RESET;
        field_coef = 0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_MODULUS;
        cfg_data   = '0;
        start      = 1'b0;
        operation  = OP_ADD;
        x_first    = '0;
        y_first    = '0;
        x_second   = '0;
        y_second   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{
            '{OP_NEGATE,  16'd0,     16'd0,     16'd0,     16'd0,     1, 16'd0,  16'd0,     1'b0},
            '{OP_NEGATE,  16'd5,     16'd7,     16'd0,     16'd0,     1, 16'd5,  16'd65514, 1'b0},
            '{OP_NEG_ALT, 16'd5,     16'd7,     16'd1,     16'd1,     1, 16'd5,  16'd65514, 1'b0},
            '{OP_NEGATE,  16'd65535, 16'd65535, 16'd65535, 16'd65535, 1, 16'd14, 16'd65507, 1'b0},
            '{OP_ADD,     16'd9,     16'd3,     16'd9,     16'd40,    1, 16'd0,  16'd0,     1'b1},
            '{OP_ADD,     16'd65530, 16'd3,     16'd9,     16'd40,    1, 16'd0,  16'd0,     1'b1},
            '{OP_DOUBLE,  16'd123,   16'd0,     16'd0,     16'd0,     1, 16'd0,  16'd0,     1'b1},
            '{OP_DOUBLE,  16'd123,   16'd65521, 16'd0,     16'd0,     1, 16'd0,  16'd0,     1'b1},
            '{OP_ADD,     16'd1,     16'd2,     16'd3,     16'd4,     0, 16'd0,  16'd0,     1'b0},
            '{OP_ADD,     16'd65535, 16'd65535, 16'd0,     16'd0,     0, 16'd0,  16'd0,     1'b0},
            '{OP_ADD,     16'd0,     16'd0,     16'd65520, 16'd65520, 0, 16'd0,  16'd0,     1'b0},
            '{OP_DOUBLE,  16'd1,     16'd1,     16'd0,     16'd0,     0, 16'd0,  16'd0,     1'b0},
            '{OP_DOUBLE,  16'd65520, 16'd65520, 16'd65535, 16'd65535, 0, 16'd0,  16'd0,     1'b0},
            '{OP_DOUBLE,  16'd0,     16'd65535, 16'd0,     16'd0,     0, 16'd0,  16'd0,     1'b0}
        };
        foreach (directed[i])
            issue_point(directed[i]);

        phases = '{
            '{16'd65521, 16'd0,     300},
            '{16'd65521, 16'd65535, 250},
            '{16'd0,     16'd0,     20},
            '{16'd1,     16'd12345, 20},
            '{16'd2,     16'd1,     40},
            '{16'd3,     16'd2,     60},
            '{16'd97,    16'd96,    200},
            '{16'd65535, 16'd7,     200},
            '{16'd65519, 16'd3,     250},
            '{16'd65521, 16'd2,     460}
        };
        foreach (phases[k])
        begin
            start <= 1'b0;
            write_reg(CFG_MODULUS, phases[k].modulus);
            write_reg(CFG_COEF_A, phases[k].coef);
            repeat (phases[k].count)
            begin
                row.known = 0;
                row.ex = '0;
                row.ey = '0;
                row.est = 1'b0;
                row.op = op_t'($urandom_range(0, 3));
                row.x1 = draw_coord();
                row.y1 = draw_coord();
                row.x2 = draw_coord();
                row.y2 = draw_coord();
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    row.x2 = row.x1;
                else if (pick == 1)
                    row.y1 = '0;
                else if (pick == 2 && field_mod != 0)
                    row.y2 = 16'((field_mod - row.y1 % field_mod) % field_mod);
                issue_point(row);
            end
        end
        start <= 1'b0;

        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
design/ecpad_pkg.sv
design/ecpad_alu.sv
design/ec_point_add_double_negate_top.sv
dv/ec_point_add_double_negate_top_test.sv
